### src/beztess_pkg.sv
// Shared types, constants and fixed-point helpers for the cubic Bezier tessellator.
// Used by beztess_ctrl, beztess_dp and cubic_bezier_curve_tessellator_top.
package beztess_pkg;

  localparam int RESOLUTION_DEF = 32;
  localparam logic [15:0] SCALE_RESET = 16'd4096;

  // Control points need one more bit than the Q3.14 results.
  localparam int CW = 19;
  // Width of a scaled handle offset before saturation.
  localparam int SW = 22;
  localparam logic signed [SW-1:0] Q314_MAX = SW'(131071);
  localparam logic signed [SW-1:0] Q314_MIN = -SW'(131072);

  typedef struct packed {
    logic latch_in;   // capture the accepted vertex
    logic scale_en;   // scale both handle y offsets
    logic ctrl_en;    // build the four control points
    logic load_prev;  // current vertex becomes the previous vertex
    logic t_clear;    // restart the t accumulator
    logic issue_seg;  // push one segment sample into the pipeline
    logic issue_fin;  // push the closing vertex into the pipeline
  } cmd_t;

  function automatic logic signed [17:0] sat_q314(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] y;
    begin
      if (x > Q314_MAX) begin
        y = Q314_MAX;
      end else if (x < Q314_MIN) begin
        y = Q314_MIN;
      end else begin
        y = x;
      end
      sat_q314 = y[17:0];
    end
  endfunction

  // a + floor((b - a) * t / 2^16); the result always lies between a and b.
  function automatic logic signed [CW-1:0] lerp(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b,
                                                input logic [15:0] t);
    logic signed [CW:0]    d;
    logic signed [CW+17:0] p;
    logic signed [CW+17:0] s;
    begin
      d = (CW+1)'(b) - (CW+1)'(a);
      p = (CW+18)'(d) * (CW+18)'($signed({1'b0, t}));
      s = p >>> 16;
      lerp = a + s[CW-1:0];
    end
  endfunction

  // Handle y times an unsigned Q4.12 factor, floored, then saturated to Q3.14.
  function automatic logic signed [17:0] scale_hy(input logic signed [16:0] hy,
                                                  input logic [15:0] scale);
    logic signed [33:0] p;
    logic signed [33:0] s;
    begin
      p = 34'(hy) * 34'($signed({1'b0, scale}));
      s = p >>> 12;
      scale_hy = sat_q314(s[SW-1:0]);
    end
  endfunction

endpackage

### src/beztess_ctrl.sv
// Sequencer of the Bezier tessellator: accepts vertices and steps the datapath.
// Depends on beztess_pkg (cmd_t).
module beztess_ctrl #(
  parameter int RESOLUTION = beztess_pkg::RESOLUTION_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                final_vertex,
  input  logic                adv,
  output beztess_pkg::cmd_t   cmd
);
  import beztess_pkg::*;

  localparam int JW = $clog2(RESOLUTION);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_SCALE,
    ST_CTRL,
    ST_RUN,
    ST_FINAL
  } state_t;

  state_t         state;
  logic [JW-1:0]  j;
  logic           fin;
  logic           have_previous;
  logic           accept;
  logic           last_j;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign last_j   = (j == JW'(RESOLUTION - 1));

  always_comb begin
    cmd           = '0;
    cmd.latch_in  = accept;
    cmd.load_prev = (state == ST_STORE) || ((state == ST_CTRL) && !fin);
    cmd.scale_en  = (state == ST_SCALE);
    cmd.ctrl_en   = (state == ST_CTRL);
    cmd.t_clear   = (state == ST_CTRL);
    cmd.issue_seg = (state == ST_RUN) && adv;
    cmd.issue_fin = (state == ST_FINAL) && adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      j             <= '0;
      fin           <= 1'b0;
      have_previous <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            fin <= final_vertex;
            if (have_previous) begin
              state <= ST_SCALE;
            end else if (final_vertex) begin
              state <= ST_FINAL;
            end else begin
              state <= ST_STORE;
            end
          end
        end
        ST_STORE: begin
          have_previous <= 1'b1;
          state         <= ST_IDLE;
        end
        ST_SCALE: begin
          state <= ST_CTRL;
        end
        ST_CTRL: begin
          j     <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (adv) begin
            if (last_j) begin
              j     <= '0;
              state <= fin ? ST_FINAL : ST_IDLE;
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        ST_FINAL: begin
          if (adv) begin
            have_previous <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Of segment issue, closing issue, scaling and vertex capture, at most one is commanded in a cycle.
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.issue_seg, cmd.issue_fin, cmd.scale_en, cmd.latch_in}))
    else $error("beztess_ctrl: conflicting datapath commands");

  // A vertex that follows a stored one always starts a segment.
  a_seg_start: assert property (@(posedge clk) disable iff (rst)
    accept && have_previous |=> state == ST_SCALE)
    else $error("beztess_ctrl: segment not started");

  // The sample counter wraps when the segment ends.
  a_j_wrap: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && adv && last_j |=> j == '0 && state != ST_RUN)
    else $error("beztess_ctrl: segment did not end after the last sample");

endmodule

### src/beztess_dp.sv
// Datapath of the Bezier tessellator: vertex and handle registers, control points,
// t accumulator and a three-level de Casteljau pipeline. Depends on beztess_pkg.
module beztess_dp #(
  parameter int RESOLUTION = beztess_pkg::RESOLUTION_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  beztess_pkg::cmd_t         cmd,
  output logic                      adv,
  input  logic                      cfg_we,
  input  logic [15:0]               cfg_data,
  input  logic signed [15:0]        vertex_x,
  input  logic signed [15:0]        vertex_y,
  input  logic [15:0]               handle_x,
  input  logic signed [16:0]        handle_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [17:0]        point_x,
  output logic signed [17:0]        point_y,
  output logic                      last_point
);
  import beztess_pkg::*;

  localparam int TQ = 65536 / RESOLUTION;
  localparam int TR = 65536 % RESOLUTION;
  localparam int RW = $clog2(RESOLUTION) + 1;

  logic [15:0]          scale;
  logic signed [15:0]   cur_vx, cur_vy, prev_vx, prev_vy;
  logic [15:0]          cur_hx, prev_hx;
  logic signed [16:0]   cur_hy, prev_hy;
  logic signed [17:0]   shy_a, shy_b;
  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];
  logic [15:0]          tq;
  logic [RW-1:0]        tr;
  logic [RW-1:0]        tr_sum;

  // Pipeline registers.
  logic                 v1, v2, last1, last2;
  logic [15:0]          t1, t2;
  logic signed [CW-1:0] hx [3];
  logic signed [CW-1:0] hy [3];
  logic signed [CW-1:0] lx [2];
  logic signed [CW-1:0] ly [2];

  // Stage-one operands.
  logic signed [CW-1:0] sx [4];
  logic signed [CW-1:0] sy [4];
  logic [15:0]          st;
  logic                 issue;

  assign adv    = !out_valid || !out_stall;
  assign issue  = cmd.issue_seg || cmd.issue_fin;
  assign tr_sum = tr + RW'(TR);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cur_vx <= vertex_x;
      cur_vy <= vertex_y;
      cur_hx <= handle_x;
      cur_hy <= handle_y;
    end
    if (cmd.load_prev) begin
      prev_vx <= cur_vx;
      prev_vy <= cur_vy;
      prev_hx <= cur_hx;
      prev_hy <= cur_hy;
    end
    if (cmd.scale_en) begin
      shy_a <= scale_hy(prev_hy, scale);
      shy_b <= scale_hy(cur_hy, scale);
    end
    if (cmd.ctrl_en) begin
      px[0] <= CW'(prev_vx);
      px[1] <= CW'(prev_vx) + CW'($signed({1'b0, prev_hx}));
      px[2] <= CW'(cur_vx) - CW'($signed({1'b0, cur_hx}));
      px[3] <= CW'(cur_vx);
      py[0] <= CW'(prev_vy);
      py[1] <= CW'(prev_vy) + CW'(shy_a);
      py[2] <= CW'(cur_vy) - CW'(shy_b);
      py[3] <= CW'(cur_vy);
    end
  end

  // t = floor(j * 2^16 / RESOLUTION), kept as quotient and remainder.
  always_ff @(posedge clk) begin
    if (cmd.t_clear) begin
      tq <= '0;
      tr <= '0;
    end else if (cmd.issue_seg) begin
      if (tr_sum >= RW'(RESOLUTION)) begin
        tr <= tr_sum - RW'(RESOLUTION);
        tq <= tq + 16'(TQ + 1);
      end else begin
        tr <= tr_sum;
        tq <= tq + 16'(TQ);
      end
    end
  end

  // The closing vertex runs through the same pipeline as a degenerate curve.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sx[k] = cmd.issue_fin ? CW'(cur_vx) : px[k];
      sy[k] = cmd.issue_fin ? CW'(cur_vy) : py[k];
    end
    st = cmd.issue_fin ? 16'd0 : tq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= issue;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last1 <= cmd.issue_fin;
      t1    <= st;
      for (int k = 0; k < 3; k++) begin
        hx[k] <= lerp(sx[k], sx[k+1], st);
        hy[k] <= lerp(sy[k], sy[k+1], st);
      end
      last2 <= last1;
      t2    <= t1;
      for (int k = 0; k < 2; k++) begin
        lx[k] <= lerp(hx[k], hx[k+1], t1);
        ly[k] <= lerp(hy[k], hy[k+1], t1);
      end
      last_point <= last2;
      point_x    <= sat_q314(SW'(lerp(lx[0], lx[1], t2)));
      point_y    <= sat_q314(SW'(lerp(ly[0], ly[1], t2)));
    end
  end

  // Samples are only pushed when the pipeline moves.
  a_issue_adv: assert property (@(posedge clk) disable iff (rst)
    issue |-> adv)
    else $error("beztess_dp: sample issued into a stalled pipeline");

  // A closing point issued while an output beat is taken enters stage one marked last.
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    cmd.issue_fin && out_valid && !out_stall |=> v1 && last1)
    else $error("beztess_dp: closing point lost in stage one");

  // A held result keeps its point.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(point_x) && $stable(point_y))
    else $error("beztess_dp: stalled point changed");

endmodule

### src/cubic_bezier_curve_tessellator_top.sv
// Cubic Bezier curve tessellator, top level.
// Depends on beztess_pkg, beztess_ctrl and beztess_dp.
//
// Usage: vertices of a curve enter in order on the input channel, one beat each,
// with their tangent handle; final_vertex marks the last one. Each beat is taken
// when in_valid is high and in_stall is low. Every vertex after the first of a
// curve yields RESOLUTION points of the segment from the previous vertex, sampled
// by de Casteljau at t = j/RESOLUTION. After the final vertex the vertex itself
// follows with last_point set, and the next beat starts a new curve.
// The output channel moves one point per beat when out_valid is high and
// out_stall is low. The config channel writes handle_y_scale (Q4.12) when
// cfg_valid and cfg_ready are high; it is always ready and should be written
// only while the block is idle.
// Sequencing: a vertex with a stored predecessor holds the input while the
// sequencer scales the handles, builds the control points and issues one sample a
// cycle, unless the output stalls, into the three-level interpolation pipeline,
// then the vertex itself if final. A first vertex that is not final is only stored.
// Each level is registered. When the receiver stalls, the pipeline freezes, the
// sequencer stops issuing samples and the output point holds. Synchronous reset
// empties the pipeline, forgets the stored vertex and sets handle_y_scale to 1.0.
module cubic_bezier_curve_tessellator_top #(
  parameter int RESOLUTION = beztess_pkg::RESOLUTION_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] vertex_x,
  input  logic signed [15:0] vertex_y,
  input  logic [15:0]        handle_x,
  input  logic signed [16:0] handle_y,
  input  logic               final_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] point_x,
  output logic signed [17:0] point_y,
  output logic               last_point,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        handle_y_scale
);
  import beztess_pkg::*;

  cmd_t cmd;
  logic adv;

  // The scale register can take a write in any cycle.
  assign cfg_ready = 1'b1;

  beztess_ctrl #(
    .RESOLUTION(RESOLUTION)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .final_vertex (final_vertex),
    .adv          (adv),
    .cmd          (cmd)
  );

  beztess_dp #(
    .RESOLUTION(RESOLUTION)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .adv        (adv),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (handle_y_scale),
    .vertex_x   (vertex_x),
    .vertex_y   (vertex_y),
    .handle_x   (handle_x),
    .handle_y   (handle_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point)
  );

endmodule

### bench/cubic_bezier_curve_tessellator_top_tb.sv
// Self-checking testbench for cubic_bezier_curve_tessellator_top.
// Depends on beztess_pkg and the tessellator RTL. It predicts every curve
// point in SystemVerilog and checks each output beat against that prediction.
module cubic_bezier_curve_tessellator_top_tb;

  import beztess_pkg::*;

  localparam int RESOLUTION = RESOLUTION_DEF;
  localparam int CLK_HALF = 4;
  // This margin covers the whole hold that a vertex puts on the input and the
  // trip of a point through the pipeline levels after it is issued.
  localparam int DRAIN_CYCLES = RESOLUTION + 10;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int LIMIT_CYCLES = 4_000_000;

  // One vertex beat as the sender sees it.
  typedef struct {
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] hx;
    logic [16:0] hy;
    logic        fin;
  } vertex_t;

  // One curve point as the receiver sees it.
  typedef struct {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic               last;
  } point_t;

  // Ports of the block. Every input starts at a known value.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] vertex_x = '0;
  logic signed [15:0] vertex_y = '0;
  logic [15:0]        handle_x = '0;
  logic signed [16:0] handle_y = '0;
  logic               final_vertex = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [17:0] point_x;
  logic signed [17:0] point_y;
  logic               last_point;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        handle_y_scale = '0;

  cubic_bezier_curve_tessellator_top #(
    .RESOLUTION(RESOLUTION)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .vertex_x(vertex_x),
    .vertex_y(vertex_y),
    .handle_x(handle_x),
    .handle_y(handle_y),
    .final_vertex(final_vertex),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .point_x(point_x),
    .point_y(point_y),
    .last_point(last_point),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .handle_y_scale(handle_y_scale)
  );

  // Vertices waiting to be sent, and curve points waiting to be seen.
  vertex_t pending_vertices[$];
  point_t  curve_points[$];

  // The predictor's own copy of the block state and its scale register.
  logic [15:0] y_scale;
  logic [15:0] last_vx;
  logic [15:0] last_vy;
  logic [15:0] last_hx;
  logic [16:0] last_hy;
  logic        curve_open;

  // Handshake bookkeeping shared between the clocked blocks.
  logic in_fire = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  bit   calm_in = 1'b0;
  bit   calm_out = 1'b0;

  int errors = 0;
  int vertices_seen = 0;
  int points_checked = 0;
  int scale_writes = 0;
  int random_queued = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Hang guard. It is sized for every result stalled to the longest gap,
  // several times over, so it only fires when the block stops moving.
  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("cubic_bezier_curve_tessellator_top_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Fixed-point arithmetic of the curve. longint is wide enough for every
  // product here, and >>> on a signed value floors toward minus infinity.
  // ---------------------------------------------------------------------
  function automatic longint clamp_q314(input longint v);
    if (v > 131071) begin
      return 131071;
    end else if (v < -131072) begin
      return -131072;
    end
    return v;
  endfunction

  function automatic longint scaled_offset(input longint hy);
    return clamp_q314((hy * longint'(y_scale)) >>> 12);
  endfunction

  function automatic longint lerp_q16(input longint a, input longint b, input longint t);
    return a + (((b - a) * t) >>> 16);
  endfunction

  // Three levels of de Casteljau interpolation, saturated at the end.
  function automatic longint bezier_sample(input longint p1, input longint p2,
                                           input longint p3, input longint p4,
                                           input longint t);
    longint h1, h2, h3, l1, l2;
    h1 = lerp_q16(p1, p2, t);
    h2 = lerp_q16(p2, p3, t);
    h3 = lerp_q16(p3, p4, t);
    l1 = lerp_q16(h1, h2, t);
    l2 = lerp_q16(h2, h3, t);
    return clamp_q314(lerp_q16(l1, l2, t));
  endfunction

  // Works out the points that one accepted vertex causes and updates the
  // stored predecessor. A vertex that opens a curve causes nothing unless it
  // is also final; a final vertex always closes with the vertex itself.
  task automatic predict_vertex(input vertex_t v);
    longint ax, ay, bx, by, c1x, c1y, c2x, c2y, tq;
    point_t p;
    bx = longint'($signed(v.vx));
    by = longint'($signed(v.vy));
    if (curve_open) begin
      ax  = longint'($signed(last_vx));
      ay  = longint'($signed(last_vy));
      c1x = ax + longint'(last_hx);
      c1y = ay + scaled_offset(longint'($signed(last_hy)));
      c2x = bx - longint'(v.hx);
      c2y = by - scaled_offset(longint'($signed(v.hy)));
      for (int j = 0; j < RESOLUTION; j++) begin
        tq = (longint'(j) << 16) / RESOLUTION;
        p.x = 18'(bezier_sample(ax, c1x, c2x, bx, tq));
        p.y = 18'(bezier_sample(ay, c1y, c2y, by, tq));
        p.last = 1'b0;
        curve_points = {curve_points, p};
      end
    end
    if (v.fin) begin
      p.x = 18'(clamp_q314(bx));
      p.y = 18'(clamp_q314(by));
      p.last = 1'b1;
      curve_points = {curve_points, p};
      curve_open = 1'b0;
    end else begin
      last_vx = v.vx;
      last_vy = v.vy;
      last_hx = v.hx;
      last_hy = v.hy;
      curve_open = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(30, 90);
  endfunction

  // A value in -lim..lim, with the two ends picked more often than chance.
  function automatic int pick_span(input int lim);
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      return -lim;
    end else if (r == 1) begin
      return lim;
    end
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  // Most vertices stay inside the documented ranges. A few use the full
  // port widths, which pushes the sums outside Q3.14 and into saturation.
  function automatic vertex_t rand_vertex(input logic fin);
    vertex_t v;
    int r;
    v.fin = fin;
    if ($urandom_range(99) < 12) begin
      v.vx = 16'($urandom());
      v.vy = 16'($urandom());
      v.hx = 16'($urandom());
      v.hy = 17'($urandom());
    end else begin
      v.vx = 16'(pick_span(16384));
      v.vy = 16'(pick_span(16384));
      r = $urandom_range(9);
      v.hx = (r == 0) ? 16'd0 : (r == 1) ? 16'd32768 : 16'($urandom_range(32768));
      v.hy = 17'(pick_span(32768));
    end
    return v;
  endfunction

  task automatic add_vertex(input int vx, input int vy, input int hx, input int hy,
                            input logic fin);
    vertex_t v;
    v.vx = 16'(vx);
    v.vy = 16'(vy);
    v.hx = 16'(hx);
    v.hy = 17'(hy);
    v.fin = fin;
    pending_vertices = {pending_vertices, v};
  endtask

  // One curve closed by a final vertex. A lone final vertex shows up now and
  // then, which is the case of a curve with no segment at all.
  task automatic add_random_curve();
    int n;
    n = ($urandom_range(99) < 10) ? 1 : $urandom_range(2, 6);
    for (int k = 0; k < n; k++) begin
      pending_vertices = {pending_vertices, rand_vertex(k == n - 1)};
    end
    random_queued += n;
  endtask

  // Writes the scale register. The block is idle whenever this is called.
  task automatic write_scale(input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    handle_y_scale <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    scale_writes++;
  endtask

  // Holds the sender back until every queued vertex is sent and every
  // predicted point has come out, then lets the block settle. A vertex that
  // opens a curve causes no point, so the extra cycles cover it as well.
  task automatic wait_idle();
    do @(posedge clk); while (pending_vertices.size() != 0 || in_valid ||
                              curve_points.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Input driver. It changes the vertex beat at the falling edge, holds a
  // beat that has not been taken, and inserts random gaps between beats.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    vertex_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // The beat is stalled and stays exactly as it is.
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pending_vertices.size() != 0) begin
      nxt = pending_vertices.pop_front();
      vertex_x <= nxt.vx;
      vertex_y <= nxt.vy;
      handle_x <= nxt.hx;
      handle_y <= nxt.hy;
      final_vertex <= nxt.fin;
      in_valid <= 1'b1;
      send_gap = calm_in ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output stall. Stall stretches start at random cycles, so they can land on
  // any point of a segment, the closing point included.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm_out && $urandom_range(3) == 0) begin
        stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor. At each rising edge it checks an output beat against the oldest
  // predicted point, tracks register writes, and predicts from input beats.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    point_t want;
    in_fire <= in_valid && !in_stall && !rst;
    if (rst) begin
      y_scale = SCALE_RESET;
      last_vx = '0;
      last_vy = '0;
      last_hx = '0;
      last_hy = '0;
      curve_open = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        points_checked++;
        if (curve_points.size() == 0) begin
          errors++;
          $display("%0t: point beat with nothing predicted: x %0d y %0d last %0b",
                   $realtime, point_x, point_y, last_point);
        end else begin
          want = curve_points.pop_front();
          if (point_x !== want.x || point_y !== want.y || last_point !== want.last) begin
            errors++;
            $display("%0t: point mismatch: expected x %0d y %0d last %0b,",
                     $realtime, want.x, want.y, want.last,
                     " actual x %0d y %0d last %0b", point_x, point_y, last_point);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        y_scale = handle_y_scale;
      end
      if (in_valid && !in_stall) begin
        vertex_t got;
        got.vx = vertex_x;
        got.vy = vertex_y;
        got.hx = handle_x;
        got.hy = handle_y;
        got.fin = final_vertex;
        vertices_seen++;
        predict_vertex(got);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    logic [15:0] scale;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed curves at the reset scale of 1.0. A lone final vertex comes
    // first, then one with raw extreme fields, then curves whose vertices and
    // handles sit on the ends of their ranges and beyond.
    calm_in = 1'b0;
    calm_out = 1'b0;
    add_vertex(16384, -16384, 0, 0, 1'b1);
    add_vertex(-32768, 32767, 65535, 65536, 1'b1);
    add_vertex(-16384, -16384, 0, -32768, 1'b0);
    add_vertex(16384, 16384, 32768, 32768, 1'b0);
    add_vertex(0, 0, 65535, -65536, 1'b1);
    add_vertex(16384, 16384, 32768, 32768, 1'b0);
    add_vertex(-16384, -16384, 32768, -32768, 1'b1);
    // Full-width vertices and handles put the control points far outside the vertex range.
    add_vertex(32767, -32768, 65535, 65535, 1'b0);
    add_vertex(-32768, 32767, 65535, -65536, 1'b1);
    add_vertex(0, 0, 0, 0, 1'b0);
    add_vertex(0, 0, 0, 0, 1'b1);
    add_vertex(100, -200, 5000, -7000, 1'b0);
    add_vertex(-3000, 4000, 1234, 20000, 1'b0);
    add_vertex(8000, -8000, 16384, 0, 1'b0);
    add_vertex(-16384, 16384, 0, 32768, 1'b1);
    wait_idle();

    // Random phases, each under its own scale. The first few pin the scale
    // to its extremes; the sender waits for every point between phases.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       scale = 16'hFFFF;
        1:       scale = 16'h0000;
        2:       scale = 16'd1;
        3:       scale = SCALE_RESET;
        4:       scale = 16'd8192;
        default: scale = 16'($urandom());
      endcase
      write_scale(scale);
      calm_in = (phase == 2);
      calm_out = (phase == 3);
      random_queued = 0;
      while (random_queued < ITEMS_PER_PHASE) begin
        add_random_curve();
      end
      wait_idle();
    end

    $display("run covered %0d vertices and %0d checked points under %0d scale writes",
             vertices_seen, points_checked, scale_writes);
    $display("curves included lone final vertices, saturated handles and full-width fields");
    if (errors == 0) begin
      $display("cubic_bezier_curve_tessellator_top_tb: clean");
    end else begin
      $display("cubic_bezier_curve_tessellator_top_tb: errors");
    end
    $finish;
  end

endmodule
